FILE: hdl/stbs_pkg.sv
// Package for the sorted table binary search block.
// Field widths, word codes and the shared word types; no dependencies.
package stbs_pkg;

    localparam int IDX_W   = 10;          // width of an index field
    localparam int FIELD_W = 32;          // width of a value or key field
    localparam int BND_W   = IDX_W + 1;   // search bound, holds one past the last index

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    typedef struct packed {
        logic                      kind;
        logic [IDX_W-1:0]          entry_index;
        logic signed [FIELD_W-1:0] entry_value;
        logic signed [FIELD_W-1:0] search_key;
        logic [IDX_W-1:0]          low_index;
        logic [IDX_W-1:0]          high_index;
    } stbs_cmd_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] match_index;
    } stbs_result_t;

endpackage

FILE: hdl/stbs_cmd_if.sv
// Command channel: load and search words.
// Depends on stbs_pkg for field widths.
interface stbs_cmd_if
    import stbs_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [IDX_W-1:0]          entry_index;
    logic signed [FIELD_W-1:0] entry_value;
    logic signed [FIELD_W-1:0] search_key;
    logic [IDX_W-1:0]          low_index;
    logic [IDX_W-1:0]          high_index;

    modport source (
        output valid, kind, entry_index, entry_value, search_key, low_index, high_index,
        input  ready
    );

    modport sink (
        input  valid, kind, entry_index, entry_value, search_key, low_index, high_index,
        output ready
    );
endinterface

FILE: hdl/stbs_rsp_if.sv
// Response channel: search results.
// Depends on stbs_pkg for field widths.
interface stbs_rsp_if
    import stbs_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             found;
    logic [IDX_W-1:0] match_index;

    modport source (
        output valid, found, match_index,
        input  ready
    );

    modport sink (
        input  valid, found, match_index,
        output ready
    );
endinterface

FILE: hdl/sorted_table_binary_search.sv
// Top level of the sorted table binary search block.
// Depends on stbs_pkg, stbs_cmd_if, stbs_rsp_if, stbs_table and stbs_ctrl.
//
//  channel | dir | words carried                     | result
//  --------+-----+-----------------------------------+------------------
//  cmd     | in  | kind = load: entry_index/value    | none
//          |     | kind = search: key, low/high index| one rsp word
//  rsp     | out | found, match_index                | -
//
// Loads may follow back to back.
// A search steps through accept, the probes, a final bound check or match,
// and the hand-off to rsp; each probe waits on the table RAM's registered
// read before it compares the key and narrows the bounds.
// cmd.ready is low while a search is in progress; the result sits in the
// rsp register, so the next command is taken while rsp is stalled.
// rst_n clears the control state only; the table holds no reset value and
// must be loaded before it is searched.
module sorted_table_binary_search
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    stbs_cmd_if.sink cmd,
    stbs_rsp_if.source rsp
);

    localparam int AW = $clog2(TABLE_DEPTH);

    stbs_cmd_t                     cmd_word;
    logic                          mem_we;
    logic                          mem_re;
    logic [AW-1:0]                 mem_addr;
    logic signed [VALUE_WIDTH-1:0] mem_wdata;
    logic signed [VALUE_WIDTH-1:0] mem_rdata;
    logic                          res_valid;
    stbs_result_t                  res;
    logic                          res_take;
    logic                          rsp_valid_reg;
    stbs_result_t                  rsp_word_reg;

    // gather the command fields into one word for the sequencer
    assign cmd_word.kind        = cmd.kind;
    assign cmd_word.entry_index = cmd.entry_index;
    assign cmd_word.entry_value = cmd.entry_value;
    assign cmd_word.search_key  = cmd.search_key;
    assign cmd_word.low_index   = cmd.low_index;
    assign cmd_word.high_index  = cmd.high_index;

    stbs_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .cmd       (cmd_word),
        .mem_we    (mem_we),
        .mem_re    (mem_re),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    stbs_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // output register: free when empty or being drained this cycle
    assign res_take = !rsp_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid && res_take)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            rsp_word_reg <= res;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.found       = rsp_word_reg.found;
    assign rsp.match_index = rsp_word_reg.match_index;

`ifndef SYNTH
    // single-port table: never written and read together
    a_mem_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("table written and read in the same cycle");

    // a search word closes the command side in the next cycle
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && cmd.kind == KIND_SEARCH) |=> !cmd.ready)
        else $error("command accepted during a search");

    // loads never stall the command side
    a_load_streams: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && cmd.kind == KIND_LOAD) |=> cmd.ready)
        else $error("load stalled the command side");

    // a hit always points inside the table
    a_hit_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.found) |-> (32'(rsp.match_index) < TABLE_DEPTH))
        else $error("match index beyond the table");
`endif

endmodule

FILE: hdl/stbs_table.sv
// Value table: single-port synchronous RAM with a registered read.
// No package dependencies.
module stbs_table #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32,
    parameter int AW          = 10
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic                          re,
    input  logic [AW-1:0]                 addr,
    input  logic signed [VALUE_WIDTH-1:0] wdata,
    output logic signed [VALUE_WIDTH-1:0] rdata
);

    logic signed [VALUE_WIDTH-1:0] value_mem [TABLE_DEPTH];
    logic signed [VALUE_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            value_mem[addr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= value_mem[addr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

FILE: hdl/stbs_ctrl.sv
// Search sequencer: takes command words, drives the table RAM, narrows bounds.
// Depends on stbs_pkg for the word types and codes.
module stbs_ctrl
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32,
    parameter int AW          = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  stbs_cmd_t                     cmd,
    output logic                          mem_we,
    output logic                          mem_re,
    output logic [AW-1:0]                 mem_addr,
    output logic signed [VALUE_WIDTH-1:0] mem_wdata,
    input  logic signed [VALUE_WIDTH-1:0] mem_rdata,
    output logic                          res_valid,
    output stbs_result_t                  res,
    input  logic                          res_take
);

    localparam int unsigned LAST = TABLE_DEPTH - 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_CMP   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic signed [VALUE_WIDTH-1:0] key_reg, key_next;
    logic [BND_W-1:0]              lo_reg, lo_next;
    logic [BND_W-1:0]              hi_reg, hi_next;
    logic [BND_W-1:0]              mid_reg, mid_next;
    stbs_result_t                  res_reg, res_next;
    logic [BND_W-1:0]              mid;

    // lo <= hi whenever this is used, so the difference never wraps
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        res_next   = res_reg;
        cmd_ready  = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = AW'(mid);
        mem_wdata  = VALUE_WIDTH'(cmd.entry_value);
        res_valid  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    if (cmd.kind == KIND_LOAD)
                    begin
                        mem_we   = (32'(cmd.entry_index) <= LAST);
                        mem_addr = AW'(cmd.entry_index);
                    end
                    else
                    begin
                        key_next = VALUE_WIDTH'(cmd.search_key);
                        lo_next  = BND_W'(cmd.low_index);
                        if (32'(cmd.high_index) > LAST)
                        begin
                            hi_next = BND_W'(LAST);
                        end
                        else
                        begin
                            hi_next = BND_W'(cmd.high_index);
                        end
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE:
            begin
                if (lo_reg > hi_reg)
                begin
                    res_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mid_next   = mid;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (key_reg < mem_rdata)
                begin
                    if (mid_reg == '0)
                    begin
                        // bound would drop below zero
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        hi_next    = mid_reg - BND_W'(1);
                        state_next = ST_PROBE;
                    end
                end
                else if (key_reg > mem_rdata)
                begin
                    lo_next    = mid_reg + BND_W'(1);
                    state_next = ST_PROBE;
                end
                else
                begin
                    res_next.found       = 1'b1;
                    res_next.match_index = mid_reg[IDX_W-1:0];
                    state_next           = ST_DONE;
                end
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule
